>>> rtl/core/ttm_pkg.sv
`default_nettype none
package ttm_pkg;
	localparam int unsigned SLOTS = 16;
	localparam int unsigned ID_W = 4;
	localparam int unsigned CNT_W = 5;

	localparam logic [2:0] OP_ADD     = 3'd0;
	localparam logic [2:0] OP_CANCEL  = 3'd1;
	localparam logic [2:0] OP_REFRESH = 3'd2;
	localparam logic [2:0] OP_RESET   = 3'd3;
	localparam logic [2:0] OP_DELAY   = 3'd4;
	localparam logic [2:0] OP_EXPIRE  = 3'd5;

	typedef struct packed {
		logic [2:0]  operation;
		logic [63:0] now;
		logic [3:0]  timer_id;
		logic [63:0] period;
		logic        recurring;
		logic        rearm;
	} req_t;

	typedef struct packed {
		logic [3:0]  result_id;
		logic        ok;
		logic        front_notice;
		logic [63:0] delay;
		logic        last;
	} rsp_t;

	// One slot entry as held in the table memory.
	typedef struct packed {
		logic [63:0] deadline;
		logic [63:0] period;
		logic        rpt;
	} entry_t;

	// Write port from the sequencer to the table.
	typedef struct packed {
		logic                en;
		logic [ID_W-1:0]     addr;
		entry_t              data;
	} wr_t;
endpackage
`default_nettype wire

>>> rtl/core/timer_table_manager.sv
`default_nettype none
// Timer table manager: sixteen one-shot or repeating timers.
// A request is taken at a clock edge where start is high and busy is low; its
// fields come in on req. Results appear on rsp for one cycle each, marked by
// valid; rsp.last marks the final result of a request. The receiver cannot
// stall, so results are never held.
// Entries (deadline, period, repeat) live in one synchronous RAM; active bits
// and the front flag are flip-flops, cleared by reset, so no clearing pass.
// Every request scans the sixteen slots through the RAM read port, then reads
// the target entry, writes it back and registers the result. Busy drops as
// that result comes out, so the next request can be taken at the edge that
// ends it; no new request is taken while one is still in flight.
// Expire repeats the scan for each due timer it reports, so it gives n results
// (at most 16), one per scan; with nothing due it gives a single result.
// The scan length, set by the single RAM read port, limits the request rate.
// After reset the block is idle with all slots free and the front flag clear.
module timer_table_manager (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire ttm_pkg::req_t   req,
	output logic                 valid,
	output ttm_pkg::rsp_t        rsp
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_RMW  = 3'd2;
	localparam logic [2:0] ST_WB   = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]                 state_q;
	ttm_pkg::req_t              req_q;
	logic [ttm_pkg::SLOTS-1:0]  active_q;
	logic [ttm_pkg::SLOTS-1:0]  taken_q;
	logic                       front_q;
	logic [ttm_pkg::CNT_W-1:0]  cnt_q;
	logic                       rv_s1;
	logic [ttm_pkg::ID_W-1:0]   ra_s1;
	logic                       any_q;
	logic                       more_q;
	logic [ttm_pkg::ID_W-1:0]   best_q;
	logic [63:0]                bdl_q;
	logic [ttm_pkg::ID_W-1:0]   tgt_q;
	// Target deadline for the front test, known after the write-back step.
	logic [63:0]                tdl_q;
	// Repeat mark of the expired entry, captured at write-back.
	logic                       rd_rpt_q;
	logic                       valid_q;
	ttm_pkg::rsp_t              rsp_q;

	ttm_pkg::entry_t            rd;
	ttm_pkg::wr_t               wr;
	logic [ttm_pkg::ID_W-1:0]   rd_addr;

	logic [ttm_pkg::ID_W-1:0]   s;
	logic                       cand;
	logic                       better;
	logic [63:0]                newdl;
	logic [63:0]                tdl;
	logic                       ttl_live;
	logic                       full;
	logic [ttm_pkg::ID_W-1:0]   free_id;
	logic                       front;
	ttm_pkg::rsp_t              rsp_d;
	logic [ttm_pkg::SLOTS-1:0]  act_d;
	logic                       set_front;
	logic                       clr_front;
	logic                       rescan;

	ttm_table u_table (.clk(clk), .rd_addr(rd_addr), .rd_data(rd), .wr(wr));

	// Candidate selection during the scan.
	assign s = ra_s1;
	always_comb begin
		cand = 1'b0;
		unique case (req_q.operation) inside
			ttm_pkg::OP_ADD, ttm_pkg::OP_RESET:
				cand = active_q[s] && (s != tgt_q);
			ttm_pkg::OP_DELAY: cand = active_q[s];
			ttm_pkg::OP_EXPIRE:
				cand = active_q[s] && !taken_q[s] && (rd.deadline <= req_q.now);
			default: cand = 1'b0;
		endcase
		better = !any_q || (rd.deadline < bdl_q);
	end

	assign newdl = req_q.now + (req_q.operation == ttm_pkg::OP_REFRESH ?
		rd.period : req_q.period);
	assign ttl_live = active_q[tgt_q];

	// New deadline of the target, valid while the target entry is on rd.
	always_comb begin
		unique case (req_q.operation)
			ttm_pkg::OP_ADD:     tdl = newdl;
			ttm_pkg::OP_RESET:   tdl = req_q.rearm ? newdl : rd.deadline;
			ttm_pkg::OP_REFRESH: tdl = newdl;
			default:             tdl = rd.deadline;
		endcase
	end

	always_comb begin
		full = 1'b1;
		free_id = '0;
		for (int i = ttm_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				full = 1'b0;
				free_id = ttm_pkg::ID_W'(i);
			end
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign valid = valid_q;
	assign rsp = rsp_q;
	assign rd_addr = (state_q == ST_RMW) ?
		((req_q.operation == ttm_pkg::OP_EXPIRE) ? best_q : tgt_q) :
		cnt_q[ttm_pkg::ID_W-1:0];

	always_comb begin
		wr = '0;
		wr.addr = tgt_q;
		if (state_q == ST_WB) begin
			unique case (req_q.operation) inside
				ttm_pkg::OP_ADD: begin
					wr.en = !full;
					wr.data.deadline = newdl;
					wr.data.period = req_q.period;
					wr.data.rpt = req_q.recurring;
				end
				ttm_pkg::OP_REFRESH, ttm_pkg::OP_RESET: begin
					wr.en = ttl_live;
					wr.data.deadline = tdl;
					wr.data.period = (req_q.operation == ttm_pkg::OP_RESET) ?
						req_q.period : rd.period;
					wr.data.rpt = rd.rpt;
				end
				ttm_pkg::OP_EXPIRE: begin
					wr.en = any_q && rd.rpt;
					wr.data.deadline = req_q.now + rd.period;
					wr.data.period = rd.period;
					wr.data.rpt = rd.rpt;
				end
				default: wr.en = 1'b0;
			endcase
		end
	end

	// No other live timer precedes the target in (deadline, slot) order.
	assign front = !any_q || (tdl_q < bdl_q) ||
		(tdl_q == bdl_q && tgt_q < best_q);

	// Result and table updates taken at the end of a request.
	always_comb begin
		rsp_d = '0;
		rsp_d.last = 1'b1;
		act_d = active_q;
		set_front = 1'b0;
		clr_front = 1'b0;
		rescan = 1'b0;
		unique case (req_q.operation)
			ttm_pkg::OP_ADD: begin
				rsp_d.ok = !full;
				rsp_d.result_id = full ? '0 : tgt_q;
				if (!full) act_d[tgt_q] = 1'b1;
				set_front = !full && front && !front_q;
				rsp_d.front_notice = set_front;
			end
			ttm_pkg::OP_CANCEL: begin
				rsp_d.ok = ttl_live;
				if (ttl_live) act_d[tgt_q] = 1'b0;
			end
			ttm_pkg::OP_REFRESH: rsp_d.ok = ttl_live;
			ttm_pkg::OP_RESET: begin
				rsp_d.ok = ttl_live;
				set_front = ttl_live && front && !front_q;
				rsp_d.front_notice = set_front;
			end
			ttm_pkg::OP_DELAY: begin
				rsp_d.ok = 1'b1;
				clr_front = 1'b1;
				rsp_d.delay = !any_q ? '1 :
					(req_q.now >= bdl_q) ? 64'd0 : bdl_q - req_q.now;
			end
			ttm_pkg::OP_EXPIRE: begin
				if (any_q) begin
					rsp_d.ok = 1'b1;
					rsp_d.result_id = best_q;
					// Another due timer was seen, so this one is not the last.
					rsp_d.last = !more_q;
					rescan = more_q;
					if (!rd_rpt_q) act_d[best_q] = 1'b0;
				end
			end
			default: rsp_d.ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			req_q    <= '0;
			active_q <= '0;
			taken_q  <= '0;
			front_q  <= 1'b0;
			cnt_q    <= '0;
			rv_s1    <= 1'b0;
			ra_s1    <= '0;
			any_q    <= 1'b0;
			more_q   <= 1'b0;
			best_q   <= '0;
			bdl_q    <= '0;
			tgt_q    <= '0;
			tdl_q    <= '0;
			rd_rpt_q <= 1'b0;
			valid_q  <= 1'b0;
			rsp_q    <= '0;
		end else begin
			valid_q <= (state_q == ST_DONE);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q   <= req;
						cnt_q   <= '0;
						rv_s1   <= 1'b0;
						any_q   <= 1'b0;
						more_q  <= 1'b0;
						taken_q <= '0;
						state_q <= ST_SCAN;
						tgt_q   <= (req.operation == ttm_pkg::OP_ADD) ? free_id
							: req.timer_id;
					end
				end
				ST_SCAN: begin
					rv_s1 <= (cnt_q < ttm_pkg::CNT_W'(ttm_pkg::SLOTS));
					ra_s1 <= cnt_q[ttm_pkg::ID_W-1:0];
					if (cnt_q < ttm_pkg::CNT_W'(ttm_pkg::SLOTS))
						cnt_q <= cnt_q + ttm_pkg::CNT_W'(1);
					if (rv_s1 && cand) begin
						if (any_q) more_q <= 1'b1;
						if (better) begin
							any_q  <= 1'b1;
							best_q <= s;
							bdl_q  <= rd.deadline;
						end
					end
					if (!rv_s1 && cnt_q == ttm_pkg::CNT_W'(ttm_pkg::SLOTS))
						state_q <= ST_RMW;
				end
				ST_RMW: begin
					// Entry for the target (or the chosen expired slot) is read here.
					if (req_q.operation == ttm_pkg::OP_EXPIRE) tgt_q <= best_q;
					state_q <= ST_WB;
				end
				ST_WB: begin
					// rd now holds the target entry.
					tdl_q    <= tdl;
					rd_rpt_q <= rd.rpt;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					rsp_q    <= rsp_d;
					active_q <= act_d;
					if (set_front) front_q <= 1'b1;
					else if (clr_front) front_q <= 1'b0;
					if (req_q.operation == ttm_pkg::OP_EXPIRE && any_q)
						taken_q[best_q] <= 1'b1;
					if (rescan) begin
						cnt_q   <= '0;
						rv_s1   <= 1'b0;
						any_q   <= 1'b0;
						more_q  <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) valid |-> $past(busy))
		else $error("result without a request in flight");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rv_s1)
		else $error("scan pipe active while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request not taken");
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !rsp.last) |-> busy)
		else $error("request ended before its last result");
endmodule
`default_nettype wire

>>> rtl/core/ttm_table.sv
`default_nettype none
module ttm_table (
	input  wire logic                      clk,
	input  wire logic [ttm_pkg::ID_W-1:0]  rd_addr,
	output ttm_pkg::entry_t                rd_data,
	input  wire ttm_pkg::wr_t              wr
);
	ttm_pkg::entry_t mem [ttm_pkg::SLOTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	ttm_pkg::req_t req;
	logic valid;
	ttm_pkg::rsp_t rsp;

	timer_table_manager uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.valid(valid),
		.rsp(rsp)
	);

	// Predicted timer table.
	logic [63:0] tm_deadline [ttm_pkg::SLOTS];
	logic [63:0] tm_period [ttm_pkg::SLOTS];
	logic        tm_repeat [ttm_pkg::SLOTS];
	logic        tm_live [ttm_pkg::SLOTS];
	logic        tm_front;

	ttm_pkg::rsp_t pending_rsp [$];
	int errors;
	int mismatches;
	int rsp_count;
	int req_count;
	int expired_count;
	longint unsigned cycles;
	bit quiet;
	logic [63:0] clock_now;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 1000000) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic bit slot_precedes(int a, int b);
		if (tm_deadline[a] != tm_deadline[b])
			return tm_deadline[a] < tm_deadline[b];
		return a < b;
	endfunction

	function automatic bit front_check(int s);
		for (int i = 0; i < ttm_pkg::SLOTS; i++)
			if (i != s && tm_live[i] && slot_precedes(i, s))
				return 1'b0;
		if (!tm_front) begin
			tm_front = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic ttm_pkg::rsp_t make_rsp(int id, bit ok, bit fn, logic [63:0] d,
			bit lst);
		ttm_pkg::rsp_t r;
		r.result_id = id[3:0];
		r.ok = ok;
		r.front_notice = fn;
		r.delay = d;
		r.last = lst;
		return r;
	endfunction

	task automatic expect_rsp(input ttm_pkg::rsp_t r);
		pending_rsp = {pending_rsp, r};
	endtask

	task automatic predict_timer_op(input ttm_pkg::req_t q);
		int s;
		bit live;
		bit fn;
		bit any;
		int best;
		int n;
		bit taken [ttm_pkg::SLOTS];
		int order [ttm_pkg::SLOTS];
		logic [63:0] d;
		s = q.timer_id;
		live = tm_live[s];
		fn = 1'b0;
		case (q.operation)
			ttm_pkg::OP_ADD: begin
				best = -1;
				for (int i = 0; i < ttm_pkg::SLOTS; i++)
					if (best < 0 && !tm_live[i])
						best = i;
				if (best < 0) begin
					expect_rsp(make_rsp(0, 1'b0, 1'b0, 64'd0, 1'b1));
				end else begin
					tm_live[best] = 1'b1;
					tm_repeat[best] = q.recurring;
					tm_period[best] = q.period;
					tm_deadline[best] = q.now + q.period;
					fn = front_check(best);
					expect_rsp(make_rsp(best, 1'b1, fn, 64'd0, 1'b1));
				end
			end
			ttm_pkg::OP_CANCEL: begin
				if (live)
					tm_live[s] = 1'b0;
				expect_rsp(make_rsp(0, live, 1'b0, 64'd0, 1'b1));
			end
			ttm_pkg::OP_REFRESH: begin
				if (live)
					tm_deadline[s] = q.now + tm_period[s];
				expect_rsp(make_rsp(0, live, 1'b0, 64'd0, 1'b1));
			end
			ttm_pkg::OP_RESET: begin
				if (live) begin
					tm_period[s] = q.period;
					if (q.rearm)
						tm_deadline[s] = q.now + q.period;
					fn = front_check(s);
				end
				expect_rsp(make_rsp(0, live, fn, 64'd0, 1'b1));
			end
			ttm_pkg::OP_DELAY: begin
				any = 1'b0;
				best = 0;
				d = '1;
				tm_front = 1'b0;
				for (int i = 0; i < ttm_pkg::SLOTS; i++)
					if (tm_live[i] && (!any || slot_precedes(i, best))) begin
						best = i;
						any = 1'b1;
					end
				if (any)
					d = (q.now >= tm_deadline[best]) ? 64'd0 : tm_deadline[best] - q.now;
				expect_rsp(make_rsp(0, 1'b1, 1'b0, d, 1'b1));
			end
			ttm_pkg::OP_EXPIRE: begin
				for (int i = 0; i < ttm_pkg::SLOTS; i++)
					taken[i] = 1'b0;
				n = 0;
				while (n < ttm_pkg::SLOTS) begin
					any = 1'b0;
					best = 0;
					for (int i = 0; i < ttm_pkg::SLOTS; i++)
						if (tm_live[i] && !taken[i] && tm_deadline[i] <= q.now &&
								(!any || slot_precedes(i, best))) begin
							best = i;
							any = 1'b1;
						end
					if (!any)
						break;
					taken[best] = 1'b1;
					order[n] = best;
					n++;
				end
				expired_count += n;
				if (n == 0) begin
					expect_rsp(make_rsp(0, 1'b0, 1'b0, 64'd0, 1'b1));
				end else begin
					for (int k = 0; k < n; k++) begin
						if (tm_repeat[order[k]])
							tm_deadline[order[k]] = q.now + tm_period[order[k]];
						else
							tm_live[order[k]] = 1'b0;
						expect_rsp(make_rsp(order[k], 1'b1, 1'b0, 64'd0, k == n - 1));
					end
				end
			end
			default: begin
				expect_rsp(make_rsp(0, 1'b0, 1'b0, 64'd0, 1'b1));
			end
		endcase
	endtask

	// Checks each result strobe against the oldest prediction.
	initial begin
		ttm_pkg::rsp_t want;
		forever begin
			@(posedge clk);
			if (arst_n && valid) begin
				rsp_count++;
				if (pending_rsp.size() == 0) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: %p", rsp);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.result_id !== want.result_id || rsp.ok !== want.ok ||
							rsp.front_notice !== want.front_notice ||
							rsp.delay !== want.delay || rsp.last !== want.last) begin
						errors++;
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch at cycle %0d: expected %p, got %p",
								cycles, want, rsp);
					end
				end
			end
		end
	end

	// Sends one request, optionally after a random idle gap.
	task automatic send_request(input logic [2:0] op, input logic [63:0] t,
			input logic [3:0] id, input logic [63:0] per, input bit rec, input bit fnow);
		ttm_pkg::req_t q;
		q.operation = op;
		q.now = t;
		q.timer_id = id;
		q.period = per;
		q.recurring = rec;
		q.rearm = fnow;
		if (!quiet)
			while ($urandom_range(99) < 34) begin
				start <= 1'b0;
				req <= '0;
				@(negedge clk);
			end
		start <= 1'b1;
		req <= q;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		predict_timer_op(q);
		req_count++;
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] rand_period();
		case ($urandom_range(9))
			0: return rand64();
			1: return 64'd0;
			2: return '1;
			default: return 64'($urandom_range(200));
		endcase
	endfunction

	task automatic test_directed_ops();
		send_request(ttm_pkg::OP_DELAY, 64'd0, 4'd0, 64'd0, 1'b0, 1'b0);
		send_request(ttm_pkg::OP_EXPIRE, 64'd100, 4'd0, 64'd0, 1'b0, 1'b0);
		send_request(ttm_pkg::OP_CANCEL, 64'd0, 4'd15, 64'd0, 1'b0, 1'b0);
		send_request(ttm_pkg::OP_REFRESH, 64'd0, 4'd3, 64'd0, 1'b0, 1'b0);
		send_request(ttm_pkg::OP_RESET, 64'd0, 4'd3, 64'd5, 1'b0, 1'b1);
		send_request(ttm_pkg::OP_ADD, 64'd10, 4'd0, 64'd50, 1'b1, 1'b0);
		send_request(ttm_pkg::OP_ADD, 64'd10, 4'd0, 64'd20, 1'b0, 1'b0);
		// The deadline wraps past the top of the time range here.
		send_request(ttm_pkg::OP_ADD, '1, 4'd0, 64'd3, 1'b0, 1'b0);
		send_request(ttm_pkg::OP_ADD, 64'd0, 4'd0, '1, 1'b1, 1'b0);
		send_request(ttm_pkg::OP_DELAY, 64'd15, 4'd0, 64'd0, 1'b0, 1'b0);
		send_request(ttm_pkg::OP_RESET, 64'd15, 4'd1, 64'd1, 1'b0, 1'b1);
		send_request(ttm_pkg::OP_RESET, 64'd15, 4'd0, 64'd7, 1'b0, 1'b0);
		send_request(ttm_pkg::OP_REFRESH, 64'd20, 4'd0, 64'd0, 1'b0, 1'b0);
		send_request(ttm_pkg::OP_DELAY, '1, 4'd0, 64'd0, 1'b0, 1'b0);
		send_request(ttm_pkg::OP_EXPIRE, 64'd80, 4'd0, 64'd0, 1'b0, 1'b0);
		send_request(ttm_pkg::OP_CANCEL, 64'd0, 4'd3, 64'd0, 1'b0, 1'b0);
		send_request(3'd6, 64'd0, 4'd0, 64'd0, 1'b0, 1'b0);
		send_request(3'd7, '1, 4'd15, '1, 1'b1, 1'b1);
	endtask

	// Fills the table, overflows it, lets every timer fall due at once, then cancels each slot.
	task automatic test_full_table();
		for (int i = 0; i < 17; i++)
			send_request(ttm_pkg::OP_ADD, 64'd1000, 4'd0, 64'($urandom_range(3)),
				1'($urandom_range(1)), 1'b0);
		send_request(ttm_pkg::OP_EXPIRE, 64'd2000, 4'd0, 64'd0, 1'b0, 1'b0);
		send_request(ttm_pkg::OP_EXPIRE, 64'd2000, 4'd0, 64'd0, 1'b0, 1'b0);
		send_request(ttm_pkg::OP_DELAY, 64'd2000, 4'd0, 64'd0, 1'b0, 1'b0);
		for (int i = 0; i < ttm_pkg::SLOTS; i++)
			send_request(ttm_pkg::OP_CANCEL, 64'd0, i[3:0], 64'd0, 1'b0, 1'b0);
	endtask

	task automatic test_random_ops(input int count);
		int pick;
		logic [3:0] id;
		bit rec;
		bit fnow;
		for (int n = 0; n < count; n++) begin
			quiet = (n >= count / 3 && n < count / 2);
			clock_now = clock_now + 64'($urandom_range(40));
			pick = $urandom_range(99);
			id = 4'($urandom);
			rec = 1'($urandom);
			fnow = 1'($urandom);
			if (pick < 30)
				send_request(ttm_pkg::OP_ADD, clock_now, id, rand_period(), rec, fnow);
			else if (pick < 40)
				send_request(ttm_pkg::OP_CANCEL, clock_now, id, rand64(), rec, fnow);
			else if (pick < 50)
				send_request(ttm_pkg::OP_REFRESH, clock_now, id, rand64(), rec, fnow);
			else if (pick < 62)
				send_request(ttm_pkg::OP_RESET, clock_now, id, rand_period(), rec, fnow);
			else if (pick < 75)
				send_request(ttm_pkg::OP_DELAY, clock_now, id, rand64(), rec, fnow);
			else if (pick < 97)
				send_request(ttm_pkg::OP_EXPIRE, clock_now, id, rand64(), rec, fnow);
			else if (pick < 98)
				send_request(ttm_pkg::OP_EXPIRE, rand64(), id, rand64(), rec, fnow);
			else
				send_request(3'($urandom_range(7, 6)), rand64(), id, rand64(), rec, fnow);
		end
		quiet = 1'b0;
	endtask

	initial begin
		int wait_cycles;
		errors = 0;
		mismatches = 0;
		rsp_count = 0;
		req_count = 0;
		expired_count = 0;
		quiet = 1'b0;
		clock_now = 64'd5000;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		for (int i = 0; i < ttm_pkg::SLOTS; i++) begin
			tm_deadline[i] = '0;
			tm_period[i] = '0;
			tm_repeat[i] = 1'b0;
			tm_live[i] = 1'b0;
		end
		tm_front = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_ops();
		test_full_table();
		test_random_ops(130);
		start <= 1'b0;
		req <= '0;

		wait_cycles = 0;
		while (pending_rsp.size() > 0 && wait_cycles < 20000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (400) @(negedge clk);
		errors += pending_rsp.size();
		$display("Sent %0d requests and checked %0d results, %0d of them expired timers.",
			req_count, rsp_count, expired_count);
		$display("Saw %0d mismatches.", mismatches);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

>>> files.f
rtl/core/ttm_pkg.sv
rtl/core/ttm_table.sv
rtl/core/timer_table_manager.sv
tb/tb.sv
